// ===== hw/rtl/slrb_pkg.sv =====
package slrb_pkg;

    localparam int BUFFER_DEPTH_DEF = 64;
    localparam int IDX_W            = 6;
    localparam int BYTE_W           = 8;
    localparam int FILL_W           = 7;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    typedef enum logic [1:0] {
        KIND_RECEIVE = 2'd0,
        KIND_DROP    = 2'd1,
        KIND_READ    = 2'd2,
        KIND_CLEAR   = 2'd3
    } kind_t;

    typedef enum logic [4:0] {
        ST_FETCH,
        ST_EMIT,
        ST_RX0,
        ST_RX1,
        ST_RX2,
        ST_RXOVF,
        ST_READ0,
        ST_READ1,
        ST_CLR0,
        ST_DROP0,
        ST_DROP1,
        ST_DROP2,
        ST_SHIFT0,
        ST_SH1,
        ST_SH2,
        ST_DROPEND,
        ST_WIPE
    } step_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_EMIT,
        OP_RD_PREV,
        OP_COMMIT,
        OP_SET_OVF,
        OP_RD_IDX,
        OP_LATCH_RD,
        OP_CLEAR,
        OP_SCAN_INIT,
        OP_SCAN_RD,
        OP_SHIFT_INIT,
        OP_RD_SRC,
        OP_WR_DEST,
        OP_DEC_LINES,
        OP_WIPE
    } op_t;

    typedef enum logic [3:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_IN_BEAT,
        COND_OUT_FREE,
        COND_FULL,
        COND_RX_ZERO,
        COND_NO_LINES,
        COND_PTR_END,
        COND_BYTE_NZ,
        COND_NOT_LAST
    } cond_t;

    // taken: go to target (or kind dispatch); not taken: hold or step on
    typedef struct packed {
        op_t   op;
        cond_t cond;
        logic  hold;
        logic  disp;
        step_t target;
    } ucode_t;

    function automatic ucode_t ucode_rom(step_t step);
        ucode_t w;
        w = '{op: OP_NONE, cond: COND_NEVER, hold: 1'b0, disp: 1'b0, target: ST_FETCH};
        unique case (step)
            ST_FETCH:   w = '{OP_ACCEPT,     COND_IN_BEAT,  1'b1, 1'b1, ST_FETCH};
            ST_EMIT:    w = '{OP_EMIT,       COND_OUT_FREE, 1'b1, 1'b0, ST_FETCH};
            ST_RX0:     w = '{OP_RD_PREV,    COND_FULL,     1'b0, 1'b0, ST_RXOVF};
            ST_RX1:     w = '{OP_NONE,       COND_RX_ZERO,  1'b0, 1'b0, ST_EMIT};
            ST_RX2:     w = '{OP_COMMIT,     COND_ALWAYS,   1'b0, 1'b0, ST_EMIT};
            ST_RXOVF:   w = '{OP_SET_OVF,    COND_ALWAYS,   1'b0, 1'b0, ST_EMIT};
            ST_READ0:   w = '{OP_RD_IDX,     COND_NEVER,    1'b0, 1'b0, ST_FETCH};
            ST_READ1:   w = '{OP_LATCH_RD,   COND_ALWAYS,   1'b0, 1'b0, ST_EMIT};
            ST_CLR0:    w = '{OP_CLEAR,      COND_ALWAYS,   1'b0, 1'b0, ST_EMIT};
            ST_DROP0:   w = '{OP_SCAN_INIT,  COND_NO_LINES, 1'b0, 1'b0, ST_EMIT};
            ST_DROP1:   w = '{OP_SCAN_RD,    COND_PTR_END,  1'b0, 1'b0, ST_WIPE};
            ST_DROP2:   w = '{OP_NONE,       COND_BYTE_NZ,  1'b0, 1'b0, ST_DROP1};
            ST_SHIFT0:  w = '{OP_SHIFT_INIT, COND_NEVER,    1'b0, 1'b0, ST_FETCH};
            ST_SH1:     w = '{OP_RD_SRC,     COND_NEVER,    1'b0, 1'b0, ST_FETCH};
            ST_SH2:     w = '{OP_WR_DEST,    COND_NOT_LAST, 1'b0, 1'b0, ST_SH1};
            ST_DROPEND: w = '{OP_DEC_LINES,  COND_ALWAYS,   1'b0, 1'b0, ST_EMIT};
            ST_WIPE:    w = '{OP_WIPE,       COND_ALWAYS,   1'b0, 1'b0, ST_DROPEND};
            default:    w = '{OP_NONE,       COND_ALWAYS,   1'b0, 1'b0, ST_FETCH};
        endcase
        return w;
    endfunction

endpackage

// ===== hw/rtl/slrb_ram.sv =====
module slrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/serial_line_receive_buffer_core.sv =====
// Line-oriented receive buffer for a serial link, run by a small microcoded sequencer over one
// byte store (one write and one registered read port) with a valid bit per slot, so reset and
// clear take effect at once with no clearing pass. Each input beat carries a command in tuser
// (receive, drop first line, read, clear) and gives exactly one result beat with the read byte,
// line count, fill level and overflow flag as they stand after the command. A new command is
// taken only once the previous one has finished; its result may still wait in the output
// register. Drop line scans through the single read port for the first terminator in a two-step
// loop, then shifts the rest of the buffer down in a two-step copy loop; when no terminator is
// found it wipes the buffer with no shift, and with no lines held it goes straight to the result.
module serial_line_receive_buffer_core #(
    parameter int BUFFER_DEPTH = slrb_pkg::BUFFER_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // rx_byte[7:0], read_index[13:8], zero pad
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // read_data[7:0], line_count[15:8], fill_level[22:16],
                                   // overflow_flag[23]
);

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int SW = (CW + 1 > slrb_pkg::IDX_W) ? CW + 1 : slrb_pkg::IDX_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);
    localparam logic [CW-1:0] LAST_C  = CW'(BUFFER_DEPTH - 1);
    localparam logic [SW-1:0] DEPTH_S = SW'(BUFFER_DEPTH);

    slrb_pkg::step_t  step_reg, step_next;
    slrb_pkg::ucode_t uw;
    logic             taken;

    logic [7:0]                    rx_reg, rx_next;
    logic [slrb_pkg::IDX_W-1:0]    idx_reg, idx_next;
    logic [7:0]                    rd_reg, rd_next;
    logic [CW-1:0]                 wpos_reg, wpos_next;
    logic [7:0]                    lines_reg, lines_next;
    logic                          ovf_reg, ovf_next;
    logic [CW-1:0]                 ptr_reg, ptr_next;
    logic [CW-1:0]                 skip_reg, skip_next;
    logic [BUFFER_DEPTH-1:0]       valid_reg, valid_next;
    logic                          qok_reg, qok_next;
    logic                          mvalid_reg, mvalid_next;
    logic [23:0]                   mdata_reg, mdata_next;

    logic            ram_we, ram_re;
    logic [SW-1:0]   waddr_full, raddr_full;
    logic [7:0]      ram_wdata, ram_rdata;
    logic [7:0]      rbyte;
    logic            in_beat, out_free, term;

    assign in_beat  = s_tvalid && s_tready;
    assign out_free = !mvalid_reg || m_tready;
    assign rbyte    = qok_reg ? ram_rdata : 8'h00;
    assign term     = (rx_reg == slrb_pkg::CHAR_CR) || (rx_reg == slrb_pkg::CHAR_LF)
                      || (wpos_reg == LAST_C);

    assign s_tready = (step_reg == slrb_pkg::ST_FETCH);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

    slrb_ram #(
        .WIDTH (slrb_pkg::BYTE_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (waddr_full[AW-1:0]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (raddr_full[AW-1:0]),
        .rdata (ram_rdata)
    );

    // control word decode
    always_comb begin
        uw = slrb_pkg::ucode_rom(step_reg);
    end

    // sequencer next step
    always_comb begin
        case (uw.cond)
            slrb_pkg::COND_ALWAYS:   taken = 1'b1;
            slrb_pkg::COND_IN_BEAT:  taken = in_beat;
            slrb_pkg::COND_OUT_FREE: taken = out_free;
            slrb_pkg::COND_FULL:     taken = (wpos_reg >= DEPTH_C);
            slrb_pkg::COND_RX_ZERO:  taken = (rx_reg == 8'h00);
            slrb_pkg::COND_NO_LINES: taken = (lines_reg == 8'h00);
            slrb_pkg::COND_PTR_END:  taken = (ptr_reg == DEPTH_C);
            slrb_pkg::COND_BYTE_NZ:  taken = (rbyte != 8'h00);
            slrb_pkg::COND_NOT_LAST: taken = (ptr_reg != LAST_C);
            default:                 taken = 1'b0;
        endcase

        if (taken) begin
            if (uw.disp) begin
                unique case (slrb_pkg::kind_t'(s_tuser))
                    slrb_pkg::KIND_RECEIVE: step_next = slrb_pkg::ST_RX0;
                    slrb_pkg::KIND_DROP:    step_next = slrb_pkg::ST_DROP0;
                    slrb_pkg::KIND_READ:    step_next = slrb_pkg::ST_READ0;
                    slrb_pkg::KIND_CLEAR:   step_next = slrb_pkg::ST_CLR0;
                    default:                step_next = slrb_pkg::ST_FETCH;
                endcase
            end else begin
                step_next = uw.target;
            end
        end else if (uw.hold) begin
            step_next = step_reg;
        end else begin
            step_next = slrb_pkg::step_t'(step_reg + 5'd1);
        end
    end

    // datapath
    always_comb begin
        rx_next     = rx_reg;
        idx_next    = idx_reg;
        rd_next     = rd_reg;
        wpos_next   = wpos_reg;
        lines_next  = lines_reg;
        ovf_next    = ovf_reg;
        ptr_next    = ptr_reg;
        skip_next   = skip_reg;
        valid_next  = valid_reg;
        mvalid_next = mvalid_reg && !m_tready;
        mdata_next  = mdata_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        waddr_full  = SW'(wpos_reg);
        ram_wdata   = rx_reg;
        raddr_full  = SW'(ptr_reg);

        case (uw.op)
            slrb_pkg::OP_ACCEPT: begin
                if (in_beat) begin
                    rx_next  = s_tdata[7:0];
                    idx_next = s_tdata[13:8];
                    rd_next  = 8'h00;
                end
            end
            slrb_pkg::OP_EMIT: begin
                if (out_free) begin
                    mvalid_next = 1'b1;
                    mdata_next  = {ovf_reg, slrb_pkg::FILL_W'(wpos_reg), lines_reg, rd_reg};
                end
            end
            slrb_pkg::OP_RD_PREV: begin
                ram_re     = 1'b1;
                raddr_full = SW'(wpos_reg) - SW'(1);
            end
            slrb_pkg::OP_COMMIT: begin
                ram_we     = 1'b1;
                waddr_full = SW'(wpos_reg);
                ram_wdata  = term ? 8'h00 : rx_reg;
                valid_next[waddr_full[AW-1:0]] = 1'b1;
                if (term && lines_reg != 8'hFF) begin
                    lines_next = lines_reg + 8'd1;
                end
                if (!term || rbyte != 8'h00) begin
                    wpos_next = wpos_reg + CW'(1);
                end
            end
            slrb_pkg::OP_SET_OVF: begin
                ovf_next = 1'b1;
            end
            slrb_pkg::OP_RD_IDX: begin
                ram_re     = 1'b1;
                raddr_full = SW'(idx_reg);
            end
            slrb_pkg::OP_LATCH_RD: begin
                rd_next = rbyte;
            end
            slrb_pkg::OP_CLEAR: begin
                valid_next = '0;
                wpos_next  = '0;
                lines_next = 8'h00;
                ovf_next   = 1'b0;
            end
            slrb_pkg::OP_SCAN_INIT: begin
                ptr_next = '0;
            end
            slrb_pkg::OP_SCAN_RD: begin
                ram_re     = 1'b1;
                raddr_full = SW'(ptr_reg);
                ptr_next   = ptr_reg + CW'(1);
            end
            slrb_pkg::OP_SHIFT_INIT: begin
                skip_next = ptr_reg;
                wpos_next = (wpos_reg > ptr_reg) ? wpos_reg - ptr_reg : '0;
                ptr_next  = '0;
            end
            slrb_pkg::OP_RD_SRC: begin
                ram_re     = 1'b1;
                raddr_full = SW'(ptr_reg) + SW'(skip_reg);
            end
            slrb_pkg::OP_WR_DEST: begin
                ram_we     = 1'b1;
                waddr_full = SW'(ptr_reg);
                ram_wdata  = rbyte;
                valid_next[waddr_full[AW-1:0]] = 1'b1;
                ptr_next   = ptr_reg + CW'(1);
            end
            slrb_pkg::OP_DEC_LINES: begin
                lines_next = lines_reg - 8'd1;
            end
            slrb_pkg::OP_WIPE: begin
                valid_next = '0;
                wpos_next  = '0;
            end
            default: begin
            end
        endcase

        if (ram_re) begin
            qok_next = (raddr_full < DEPTH_S) && valid_reg[raddr_full[AW-1:0]];
        end else begin
            qok_next = qok_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg   <= slrb_pkg::ST_FETCH;
            wpos_reg   <= '0;
            lines_reg  <= 8'h00;
            ovf_reg    <= 1'b0;
            valid_reg  <= '0;
            mvalid_reg <= 1'b0;
            qok_reg    <= 1'b0;
        end else begin
            step_reg   <= step_next;
            wpos_reg   <= wpos_next;
            lines_reg  <= lines_next;
            ovf_reg    <= ovf_next;
            valid_reg  <= valid_next;
            mvalid_reg <= mvalid_next;
            qok_reg    <= qok_next;
        end
    end

    always_ff @(posedge aclk) begin
        rx_reg    <= rx_next;
        idx_reg   <= idx_next;
        rd_reg    <= rd_next;
        ptr_reg   <= ptr_next;
        skip_reg  <= skip_next;
        mdata_reg <= mdata_next;
    end

    // an accepted beat always dispatches away from the fetch step
    a_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat |=> step_reg != slrb_pkg::ST_FETCH)
        else $error("sequencer stayed in fetch after a command beat");

    // store writes stay inside the buffer
    a_wr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> waddr_full < DEPTH_S)
        else $error("store write beyond buffer depth");

    // clear empties the fill level, line count, overflow flag and valid bits before the result is built
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        uw.op == slrb_pkg::OP_CLEAR |=> (wpos_reg == '0 && lines_reg == 8'h00
                                         && !ovf_reg && valid_reg == '0))
        else $error("clear left state behind");

endmodule
